@@ rtl/gpsc_pkg.sv @@
// Shared types, constants and the microcode ROM of the go-to-point speed controller.
// No dependencies; used by goto_point_speed_controller_unit.
package gpsc_pkg;

    // Arctangent table size and fixed-point constants.
    localparam int ATAN_ENTRIES = 24;
    localparam logic [30:0] HALF_PI_NRAD = 31'd1570796327;
    localparam logic [29:0] INV_GAIN_Q30 = 30'd652032874;
    localparam logic [12:0] RECIP_MEGA_Q32 = 13'd4294;
    localparam logic [19:0] MEGA = 20'd1000000;
    localparam logic [18:0] HALF_MEGA = 19'd500000;
    localparam logic [12:0] RECIP_NINE_Q16 = 13'd7282;
    localparam logic [9:0] TURN_LIMIT = 10'd698;

    // Configuration register indexes.
    localparam logic [2:0] REG_TARGET_X = 3'd0;
    localparam logic [2:0] REG_TARGET_Y = 3'd1;
    localparam logic [2:0] REG_DIST_DB = 3'd2;
    localparam logic [2:0] REG_SPEED_GAIN = 3'd3;
    localparam logic [2:0] REG_SPEED_LIMIT = 3'd4;
    localparam logic [2:0] REG_BEAR_DB = 3'd5;
    localparam logic [2:0] REG_DONE_SPEED = 3'd6;

    // Microprogram step addresses.
    localparam logic [3:0] PC_IDLE = 4'd0;
    localparam logic [3:0] PC_PREROT = 4'd1;
    localparam logic [3:0] PC_ITER = 4'd2;
    localparam logic [3:0] PC_DIST_LO = 4'd3;
    localparam logic [3:0] PC_DIST_HI = 4'd4;
    localparam logic [3:0] PC_DIST_SUM = 4'd5;
    localparam logic [3:0] PC_BRG_MUL = 4'd6;
    localparam logic [3:0] PC_BRG_QUO = 4'd7;
    localparam logic [3:0] PC_BRG_PROD = 4'd8;
    localparam logic [3:0] PC_BRG_REM = 4'd9;
    localparam logic [3:0] PC_BRG_FIX1 = 4'd10;
    localparam logic [3:0] PC_BRG_FIX2 = 4'd11;
    localparam logic [3:0] PC_TURN_MUL = 4'd12;
    localparam logic [3:0] PC_TURN = 4'd13;
    localparam logic [3:0] PC_SPEED = 4'd14;
    localparam logic [3:0] PC_EMIT = 4'd15;

    // Datapath operation selected by a control word.
    typedef enum logic [3:0] {
        OP_IDLE,
        OP_PREROT,
        OP_ITER,
        OP_DIST_LO,
        OP_DIST_HI,
        OP_DIST_SUM,
        OP_BRG_MUL,
        OP_BRG_QUO,
        OP_BRG_PROD,
        OP_BRG_REM,
        OP_BRG_FIX,
        OP_TURN_MUL,
        OP_TURN,
        OP_SPEED,
        OP_EMIT
    } t_op;

    // Sequencing condition of a control word.
    typedef enum logic [2:0] {
        COND_NEXT,
        COND_HOLD_IN,
        COND_ZERO,
        COND_LOOP,
        COND_HOLD_OUT
    } t_cond;

    typedef struct packed {
        t_op        op;
        t_cond      cond;
        logic [3:0] target;
    } t_uword;

    // Microcode ROM: one control word per step.
    function automatic t_uword ucode(input logic [3:0] pc);
        t_uword w;
        w = '{op: OP_IDLE, cond: COND_NEXT, target: PC_IDLE};
        unique case (pc)
            PC_IDLE:     w = '{op: OP_IDLE, cond: COND_HOLD_IN, target: PC_PREROT};
            PC_PREROT:   w = '{op: OP_PREROT, cond: COND_ZERO, target: PC_TURN_MUL};
            PC_ITER:     w = '{op: OP_ITER, cond: COND_LOOP, target: PC_ITER};
            PC_DIST_LO:  w = '{op: OP_DIST_LO, cond: COND_NEXT, target: PC_DIST_HI};
            PC_DIST_HI:  w = '{op: OP_DIST_HI, cond: COND_NEXT, target: PC_DIST_SUM};
            PC_DIST_SUM: w = '{op: OP_DIST_SUM, cond: COND_NEXT, target: PC_BRG_MUL};
            PC_BRG_MUL:  w = '{op: OP_BRG_MUL, cond: COND_NEXT, target: PC_BRG_QUO};
            PC_BRG_QUO:  w = '{op: OP_BRG_QUO, cond: COND_NEXT, target: PC_BRG_PROD};
            PC_BRG_PROD: w = '{op: OP_BRG_PROD, cond: COND_NEXT, target: PC_BRG_REM};
            PC_BRG_REM:  w = '{op: OP_BRG_REM, cond: COND_NEXT, target: PC_BRG_FIX1};
            PC_BRG_FIX1: w = '{op: OP_BRG_FIX, cond: COND_NEXT, target: PC_BRG_FIX2};
            PC_BRG_FIX2: w = '{op: OP_BRG_FIX, cond: COND_NEXT, target: PC_TURN_MUL};
            PC_TURN_MUL: w = '{op: OP_TURN_MUL, cond: COND_NEXT, target: PC_TURN};
            PC_TURN:     w = '{op: OP_TURN, cond: COND_NEXT, target: PC_SPEED};
            PC_SPEED:    w = '{op: OP_SPEED, cond: COND_NEXT, target: PC_EMIT};
            PC_EMIT:     w = '{op: OP_EMIT, cond: COND_HOLD_OUT, target: PC_IDLE};
            default:     w = '{op: OP_IDLE, cond: COND_NEXT, target: PC_IDLE};
        endcase
        return w;
    endfunction

    // atan(2^-i) in nanoradians, rounded to nearest.
    function automatic logic [29:0] atan_nrad(input logic [4:0] idx);
        logic [29:0] a;
        a = '0;
        unique case (idx)
            5'd0:    a = 30'd785398163;
            5'd1:    a = 30'd463647609;
            5'd2:    a = 30'd244978663;
            5'd3:    a = 30'd124354995;
            5'd4:    a = 30'd62418810;
            5'd5:    a = 30'd31239833;
            5'd6:    a = 30'd15623729;
            5'd7:    a = 30'd7812341;
            5'd8:    a = 30'd3906230;
            5'd9:    a = 30'd1953123;
            5'd10:   a = 30'd976562;
            5'd11:   a = 30'd488281;
            5'd12:   a = 30'd244141;
            5'd13:   a = 30'd122070;
            5'd14:   a = 30'd61035;
            5'd15:   a = 30'd30518;
            5'd16:   a = 30'd15259;
            5'd17:   a = 30'd7629;
            5'd18:   a = 30'd3815;
            5'd19:   a = 30'd1907;
            5'd20:   a = 30'd954;
            5'd21:   a = 30'd477;
            5'd22:   a = 30'd238;
            5'd23:   a = 30'd119;
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

@@ rtl/goto_point_speed_controller_unit.sv @@
// Go-to-point speed controller: microcoded sequencer over a CORDIC and multiplier datapath.
// Depends on gpsc_pkg for the microcode ROM, the arctangent table and constants.
// Steps: pre-rotation, shift-add CORDIC iterations (one per cycle, single unit), distance, bearing,
// turn and speed on a shared multiplier, then emit, which waits while the output stalls. A zero
// vector skips from pre-rotation to the turn step. A new request is taken only in the idle step.
// Reset (synchronous, active low) loads the register defaults and clears the goal flag.
module goto_point_speed_controller_unit
    import gpsc_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Configuration write channel
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [23:0]        i_cfg_data,
    // Position request channel
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic signed [23:0] i_current_x_mm,
    input  logic signed [23:0] i_current_y_mm,
    // Command result channel
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [11:0]        o_speed_mm_s,
    output logic signed [10:0] o_turn_mrad_s,
    output logic               o_goal_reached
);

    localparam int NSTEPS = (CORDIC_STEPS > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STEPS;
    localparam logic [4:0] LAST_STEP = 5'(NSTEPS - 1);

    // Configuration registers
    logic signed [23:0] r_target_x;
    logic signed [23:0] r_target_y;
    logic [15:0]        r_dist_db;
    logic [15:0]        r_speed_gain;
    logic [11:0]        r_speed_limit;
    logic [11:0]        r_bear_db;
    logic [11:0]        r_done_speed;

    // Sequencer and datapath registers
    logic [3:0]         r_pc;
    logic [3:0]         n_pc;
    logic [4:0]         r_i;
    logic signed [35:0] r_x;
    logic signed [35:0] r_y;
    logic signed [33:0] r_z;
    logic               r_zero;
    logic               r_neg;
    logic [31:0]        r_mag;
    logic [47:0]        r_acc;
    logic [47:0]        r_prod;
    logic [24:0]        r_dist;
    logic [11:0]        r_q;
    logic [21:0]        r_rem;
    logic signed [10:0] r_turn;
    logic [11:0]        r_speed;
    logic               r_reached;
    logic               r_out_valid;
    logic [11:0]        r_out_speed;
    logic signed [10:0] r_out_turn;
    logic               r_out_goal;

    t_uword             w;
    logic               in_accept;
    logic               out_free;
    logic               is_zero;

    // Combinational datapath helpers
    logic signed [35:0] x_shr;
    logic signed [35:0] y_shr;
    logic signed [33:0] atan_ext;
    logic [34:0]        x_clamp;
    logic [33:0]        z_abs;
    logic [65:0]        dist_sum;
    logic [32:0]        rem_diff;
    logic [12:0]        turn_n;
    logic [9:0]         turn_t;
    logic [9:0]         turn_sat;
    logic [25:0]        speed_raw;

    assign w         = ucode(r_pc);
    assign in_accept = i_in_valid && !o_in_stall;
    assign out_free  = !r_out_valid || !i_out_stall;
    assign is_zero   = (r_x == '0) && (r_y == '0);

    assign o_cfg_ready    = 1'b1;
    assign o_in_stall     = (r_pc != PC_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_speed_mm_s   = r_out_speed;
    assign o_turn_mrad_s  = r_out_turn;
    assign o_goal_reached = r_out_goal;

    // Shared shift-add and arithmetic terms
    always_comb begin
        x_shr     = r_y >>> r_i;
        y_shr     = r_x >>> r_i;
        atan_ext  = $signed({4'b0, atan_nrad(r_i)});
        x_clamp   = r_x[35] ? '0 : r_x[34:0];
        z_abs     = r_z[33] ? 34'(-r_z) : 34'(r_z);
        dist_sum  = 66'(r_acc) + {r_prod, 18'b0} + (66'd1 << 37);
        rem_diff  = {1'b0, r_mag} - {1'b0, r_prod[31:0]};
        turn_n    = {r_q, 1'b0} + 13'd4;
        turn_t    = r_prod[25:16];
        turn_sat  = (turn_t > TURN_LIMIT) ? TURN_LIMIT : turn_t;
        speed_raw = 26'((r_prod[40:0] + 41'd32768) >> 16);
    end

    // Next step address from the control word condition
    always_comb begin
        n_pc = r_pc + 4'd1;
        unique case (w.cond)
            COND_NEXT:     n_pc = r_pc + 4'd1;
            COND_HOLD_IN:  n_pc = in_accept ? w.target : r_pc;
            COND_ZERO:     n_pc = is_zero ? w.target : r_pc + 4'd1;
            COND_LOOP:     n_pc = (r_i == LAST_STEP) ? r_pc + 4'd1 : w.target;
            COND_HOLD_OUT: n_pc = out_free ? w.target : r_pc;
            default:       n_pc = PC_IDLE;
        endcase
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_x    <= '0;
            r_target_y    <= '0;
            r_dist_db     <= 16'd50;
            r_speed_gain  <= 16'd13107;
            r_speed_limit <= 12'd200;
            r_bear_db     <= 12'd175;
            r_done_speed  <= 12'd10;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_TARGET_X:    r_target_x    <= $signed(i_cfg_data);
                REG_TARGET_Y:    r_target_y    <= $signed(i_cfg_data);
                REG_DIST_DB:     r_dist_db     <= i_cfg_data[15:0];
                REG_SPEED_GAIN:  r_speed_gain  <= i_cfg_data[15:0];
                REG_SPEED_LIMIT: r_speed_limit <= i_cfg_data[11:0];
                REG_BEAR_DB:     r_bear_db     <= i_cfg_data[11:0];
                REG_DONE_SPEED:  r_done_speed  <= i_cfg_data[11:0];
                default: ;
            endcase
        end
    end

    // Control state: step counter, goal flag and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc        <= PC_IDLE;
            r_reached   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_pc <= n_pc;
            if (w.op == OP_EMIT && out_free) begin
                r_out_valid <= 1'b1;
                r_reached   <= r_reached || (r_speed < r_done_speed);
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath, one operation per control word
    always_ff @(posedge i_clk) begin
        unique case (w.op)
            OP_IDLE: begin
                if (in_accept) begin
                    r_x <= 36'(r_target_x) - 36'(i_current_x_mm);
                    r_y <= 36'(r_target_y) - 36'(i_current_y_mm);
                end
            end
            OP_PREROT: begin
                // Rotate a vector in the left half plane by a quarter turn toward +x.
                r_i    <= '0;
                r_zero <= is_zero;
                r_neg  <= 1'b0;
                r_dist <= '0;
                r_q    <= '0;
                if (!r_x[35]) begin
                    r_x <= r_x <<< 8;
                    r_y <= r_y <<< 8;
                    r_z <= '0;
                end else if (!r_y[35]) begin
                    r_x <= r_y <<< 8;
                    r_y <= (-r_x) <<< 8;
                    r_z <= $signed({3'b0, HALF_PI_NRAD});
                end else begin
                    r_x <= (-r_y) <<< 8;
                    r_y <= r_x <<< 8;
                    r_z <= -$signed({3'b0, HALF_PI_NRAD});
                end
            end
            OP_ITER: begin
                // One vectoring iteration drives y toward zero.
                if (!r_y[35]) begin
                    r_x <= r_x + x_shr;
                    r_y <= r_y - y_shr;
                    r_z <= r_z + atan_ext;
                end else begin
                    r_x <= r_x - x_shr;
                    r_y <= r_y + y_shr;
                    r_z <= r_z - atan_ext;
                end
                r_i <= r_i + 5'd1;
            end
            OP_DIST_LO: begin
                r_prod <= 48'(x_clamp[17:0] * INV_GAIN_Q30);
                r_neg  <= r_z[33];
                r_mag  <= 32'(z_abs) + 32'(HALF_MEGA);
            end
            OP_DIST_HI: begin
                r_acc  <= r_prod;
                r_prod <= 48'(x_clamp[34:18] * INV_GAIN_Q30);
            end
            OP_DIST_SUM: begin
                r_dist <= dist_sum[62:38];
            end
            OP_BRG_MUL: begin
                // Quotient estimate by reciprocal, at most two below the true value.
                r_prod <= 48'(r_mag * RECIP_MEGA_Q32);
            end
            OP_BRG_QUO: begin
                r_q <= r_prod[43:32];
            end
            OP_BRG_PROD: begin
                r_prod <= 48'(r_q * MEGA);
            end
            OP_BRG_REM: begin
                r_rem <= rem_diff[21:0];
            end
            OP_BRG_FIX: begin
                if (r_rem >= 22'(MEGA)) begin
                    r_q   <= r_q + 12'd1;
                    r_rem <= r_rem - 22'(MEGA);
                end
            end
            OP_TURN_MUL: begin
                // Division by nine through a Q16 reciprocal, exact in this range.
                r_prod <= 48'(turn_n * RECIP_NINE_Q16);
            end
            OP_TURN: begin
                if (r_q > r_bear_db) begin
                    r_turn <= (r_neg && !r_zero) ? -$signed({1'b0, turn_sat})
                                                 : $signed({1'b0, turn_sat});
                end else begin
                    r_turn <= '0;
                end
                r_prod <= 48'(r_dist * r_speed_gain);
            end
            OP_SPEED: begin
                if (r_dist > 25'(r_dist_db)) begin
                    r_speed <= (speed_raw > 26'(r_speed_limit)) ? r_speed_limit
                                                                : speed_raw[11:0];
                end else begin
                    r_speed <= '0;
                end
            end
            OP_EMIT: begin
                if (out_free) begin
                    r_out_speed <= r_speed;
                    r_out_turn  <= r_turn;
                    r_out_goal  <= r_reached || (r_speed < r_done_speed);
                end
            end
            default: ;
        endcase
    end

    // An accepted request always starts the pre-rotation step.
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (r_pc == PC_PREROT))
        else $error("accepted request did not start the microprogram");

    // The goal flag never clears once set.
    a_goal_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_reached |=> r_reached)
        else $error("goal flag cleared");

    // Reported turn rate stays within the limit.
    a_turn_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_turn_mrad_s <= 11'sd698 && o_turn_mrad_s >= -11'sd698))
        else $error("turn rate beyond limit");

    // The CORDIC counter never passes the last iteration.
    a_iter_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pc == PC_ITER) |-> (r_i <= LAST_STEP))
        else $error("CORDIC iteration count overrun");

endmodule

@@ test/speed_command_checker.sv @@
// Scoreboard for the go-to-point speed controller: it mirrors the register file, predicts the
// speed and turn command of every accepted position request and compares it with the block.
// Depends on gpsc_pkg for the register indexes.
module speed_command_checker
    import gpsc_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    input  logic               i_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [23:0]        i_cfg_data,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  logic signed [23:0] i_current_x_mm,
    input  logic signed [23:0] i_current_y_mm,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic [11:0]        i_speed_mm_s,
    input  logic signed [10:0] i_turn_mrad_s,
    input  logic               i_goal_reached,
    output int                 o_mismatches,
    output int                 o_pending,
    output int                 o_results
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ATAN_COUNT = 24;
    localparam longint QUARTER_TURN_NRAD = 64'sd1570796327;
    localparam logic [63:0] RECIP_K_Q30 = 64'd652032874;
    localparam longint MAX_TURN = 698;
    localparam int REPORT_LIMIT = 10;

    // atan(2^-i) in nanoradians, entry 0 in the lowest 30 bits.
    localparam logic [719:0] ATAN_TABLE = {
        30'd119, 30'd238, 30'd477, 30'd954, 30'd1907, 30'd3815, 30'd7629, 30'd15259,
        30'd30518, 30'd61035, 30'd122070, 30'd244141, 30'd488281, 30'd976562,
        30'd1953123, 30'd3906230, 30'd7812341, 30'd15623729, 30'd31239833,
        30'd62418810, 30'd124354995, 30'd244978663, 30'd463647609, 30'd785398163
    };

    typedef struct packed {
        logic [11:0]        speed;
        logic signed [10:0] turn;
        logic               goal;
    } t_command;

    // Shadow copy of the register file and of the sticky goal flag.
    longint aim_x;
    longint aim_y;
    longint dist_deadband;
    longint speed_gain;
    longint speed_limit;
    longint bearing_deadband;
    longint done_speed;
    logic   goal_latched;

    t_command expected_commands[$];
    int       mismatch_count;
    int       result_count;

    // Works out the command for one position sample and updates the goal flag.
    function automatic t_command predict_command(input logic signed [23:0] pos_x,
                                                 input logic signed [23:0] pos_y);
        t_command    cmd;
        longint      dx, dy, vx, vy, ang, sx, sy, step_ang;
        longint      mag, bearing, abs_bearing, turn, dist_mm, speed;
        logic [63:0] scaled;
        int          steps;
        dx = aim_x - longint'(pos_x);
        dy = aim_y - longint'(pos_y);
        steps = (CORDIC_STEPS < ATAN_COUNT) ? CORDIC_STEPS : ATAN_COUNT;
        dist_mm = 0;
        bearing = 0;
        turn = 0;
        speed = 0;
        if (dx != 0 || dy != 0) begin
            // Fold the left half-plane onto the right one with a quarter turn.
            if (dx >= 0) begin
                vx = dx;
                vy = dy;
                ang = 0;
            end else if (dy >= 0) begin
                vx = dy;
                vy = -dx;
                ang = QUARTER_TURN_NRAD;
            end else begin
                vx = -dy;
                vy = dx;
                ang = -QUARTER_TURN_NRAD;
            end
            vx = vx * 256;
            vy = vy * 256;
            // Vectoring iterations drive y toward zero and collect the angle.
            for (int i = 0; i < steps; i++) begin
                sx = vy >>> i;
                sy = vx >>> i;
                step_ang = longint'({34'd0, ATAN_TABLE[i*30 +: 30]});
                if (vy >= 0) begin
                    vx = vx + sx;
                    vy = vy - sy;
                    ang = ang + step_ang;
                end else begin
                    vx = vx - sx;
                    vy = vy + sy;
                    ang = ang - step_ang;
                end
            end
            if (vx < 0) vx = 0;
            // Remove the CORDIC gain and the input scaling with rounding.
            scaled = vx;
            dist_mm = longint'((scaled * RECIP_K_Q30 + (64'd1 << 37)) >> 38);
            mag = (ang < 0) ? -ang : ang;
            bearing = (mag + 500000) / 1000000;
            if (ang < 0) bearing = -bearing;
        end
        // Turn rate is two ninths of the bearing outside the deadband.
        abs_bearing = (bearing < 0) ? -bearing : bearing;
        if (abs_bearing > bearing_deadband) begin
            turn = (2 * abs_bearing + 4) / 9;
            if (turn > MAX_TURN) turn = MAX_TURN;
            if (bearing < 0) turn = -turn;
        end
        // Forward speed is proportional to distance outside the deadband.
        if (dist_mm > dist_deadband) begin
            speed = (dist_mm * speed_gain + 32768) >>> 16;
            if (speed > speed_limit) speed = speed_limit;
        end
        if (speed < done_speed) goal_latched = 1'b1;
        cmd.speed = speed[11:0];
        cmd.turn = turn[10:0];
        cmd.goal = goal_latched;
        return cmd;
    endfunction

    // Track register writes, queue predictions and check the results in order.
    always @(posedge i_clk) begin
        t_command seen;
        t_command want;
        if (!i_rst_n) begin
            aim_x = 0;
            aim_y = 0;
            dist_deadband = 50;
            speed_gain = 13107;
            speed_limit = 200;
            bearing_deadband = 175;
            done_speed = 10;
            goal_latched = 1'b0;
            expected_commands.delete();
            mismatch_count = 0;
            result_count = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_TARGET_X:    aim_x = longint'($signed(i_cfg_data));
                    REG_TARGET_Y:    aim_y = longint'($signed(i_cfg_data));
                    REG_DIST_DB:     dist_deadband = longint'(i_cfg_data[15:0]);
                    REG_SPEED_GAIN:  speed_gain = longint'(i_cfg_data[15:0]);
                    REG_SPEED_LIMIT: speed_limit = longint'(i_cfg_data[11:0]);
                    REG_BEAR_DB:     bearing_deadband = longint'(i_cfg_data[11:0]);
                    REG_DONE_SPEED:  done_speed = longint'(i_cfg_data[11:0]);
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                seen = '{speed: i_speed_mm_s, turn: i_turn_mrad_s, goal: i_goal_reached};
                result_count++;
                if (expected_commands.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT) begin
                        $display({"%0t checker: command with no request pending: ",
                                  "speed %0d turn %0d goal %0b"},
                                 $realtime, seen.speed, $signed(seen.turn), seen.goal);
                    end
                end else begin
                    want = expected_commands.pop_front();
                    if (seen.speed !== want.speed || seen.turn !== want.turn ||
                        seen.goal !== want.goal) begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_LIMIT) begin
                            $display({"%0t checker: expected speed %0d turn %0d goal %0b, ",
                                      "got speed %0d turn %0d goal %0b"},
                                     $realtime, want.speed, $signed(want.turn), want.goal,
                                     seen.speed, $signed(seen.turn), seen.goal);
                        end
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                expected_commands.push_back(predict_command(i_current_x_mm, i_current_y_mm));
            end
        end
        o_mismatches <= mismatch_count;
        o_pending <= expected_commands.size();
        o_results <= result_count;
    end

endmodule

@@ test/tb_goto_point_speed_controller_unit.sv @@
// Top of the go-to-point speed controller testbench: clock, reset, register writes, position
// requests and result back-pressure. Depends on gpsc_pkg, the block and speed_command_checker.
module tb_goto_point_speed_controller_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import gpsc_pkg::*;

    localparam int CORDIC_STEPS = 16;
    localparam logic [2:0] REG_UNUSED = 3'd7;
    localparam int ITEMS_PER_SET = 153;
    localparam int SETS_PER_PHASE = 4;
    localparam int HOLD_CYCLES = 400;
    localparam int QUIET_LIMIT = 4000;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [2:0]         i_cfg_index;
    logic [23:0]        i_cfg_data;
    logic               i_in_valid;
    logic               o_in_stall;
    logic signed [23:0] i_current_x_mm;
    logic signed [23:0] i_current_y_mm;
    logic               o_out_valid;
    logic               i_out_stall;
    logic [11:0]        o_speed_mm_s;
    logic signed [10:0] o_turn_mrad_s;
    logic               o_goal_reached;

    int mismatches;
    int pending;
    int results;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_requests = 0;
    int holds_served = 0;
    int positions_sent = 0;
    int settings_loaded = 0;

    // Goal currently programmed, kept for aiming requests near it.
    logic signed [23:0] aim_x = '0;
    logic signed [23:0] aim_y = '0;

    goto_point_speed_controller_unit #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_current_x_mm (i_current_x_mm),
        .i_current_y_mm (i_current_y_mm),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_speed_mm_s   (o_speed_mm_s),
        .o_turn_mrad_s  (o_turn_mrad_s),
        .o_goal_reached (o_goal_reached)
    );

    speed_command_checker #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) checker_inst (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .i_in_stall     (o_in_stall),
        .i_current_x_mm (i_current_x_mm),
        .i_current_y_mm (i_current_y_mm),
        .i_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .i_speed_mm_s   (o_speed_mm_s),
        .i_turn_mrad_s  (o_turn_mrad_s),
        .i_goal_reached (o_goal_reached),
        .o_mismatches   (mismatches),
        .o_pending      (pending),
        .o_results      (results)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Result side: random stalls, plus a long hold-off whenever one is requested.
    initial begin : result_receiver
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (holds_served < hold_requests) begin
                holds_served <= holds_served + 1;
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                i_out_stall <= ($urandom_range(99) < recv_idle_pct);
            end
        end
    end

    // Ends the run when no channel has moved a request for too long.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
                (i_cfg_valid && o_cfg_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("watchdog: no request moved for %0d cycles", QUIET_LIMIT);
        $display("tb: failure");
        $finish;
    end

    // Random offset in the range -r to r.
    function automatic int near(input int unsigned r);
        return int'($urandom_range(2 * r)) - int'(r);
    endfunction

    // Places a value under random upper bits that the register must ignore.
    function automatic logic [23:0] with_junk(input int unsigned v, input int w);
        logic [23:0] m;
        m = (24'd1 << w) - 24'd1;
        return (24'($urandom) & ~m) | (24'(v) & m);
    endfunction

    // One of two extremes, a typical value, or a random one.
    function automatic int unsigned pick(input int unsigned lo, input int unsigned hi,
                                         input int unsigned typical,
                                         input int unsigned rand_max);
        case ($urandom_range(3))
            0:       return lo;
            1:       return hi;
            2:       return typical;
            default: return $urandom_range(rand_max);
        endcase
    endfunction

    // Offers one position request, with random idle cycles in front of it.
    task automatic send_position(input logic signed [23:0] x, input logic signed [23:0] y);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_current_x_mm <= x;
        i_current_y_mm <= y;
        do @(posedge i_clk); while (o_in_stall);
        positions_sent++;
    endtask

    // Stops offering, waits for every command and then lets the block go quiet.
    task automatic drain_and_pause();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (CORDIC_STEPS + 20) @(posedge i_clk);
    endtask

    // Writes the full register file, followed by a write to an unused index.
    task automatic apply_settings(input logic signed [23:0] tx, input logic signed [23:0] ty,
                                  input int unsigned dist_db, input int unsigned gain,
                                  input int unsigned limit, input int unsigned bear_db,
                                  input int unsigned done_spd);
        logic [2:0]  idx [8];
        logic [23:0] val [8];
        idx = '{REG_TARGET_X, REG_TARGET_Y, REG_DIST_DB, REG_SPEED_GAIN, REG_SPEED_LIMIT,
                REG_BEAR_DB, REG_DONE_SPEED, REG_UNUSED};
        val = '{tx, ty, with_junk(dist_db, 16), with_junk(gain, 16), with_junk(limit, 12),
                with_junk(bear_db, 12), with_junk(done_spd, 12), 24'($urandom)};
        for (int k = 0; k < 8; k++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx[k];
            i_cfg_data <= val[k];
            do @(posedge i_clk); while (!o_cfg_ready);
        end
        i_cfg_valid <= 1'b0;
        aim_x = tx;
        aim_y = ty;
        settings_loaded++;
    endtask

    initial begin : stimulus
        logic signed [23:0] x;
        logic signed [23:0] y;
        logic signed [23:0] tx;
        logic signed [23:0] ty;
        int unsigned        kind;
        int                 failures;

        i_rst_n <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data <= '0;
        i_in_valid <= 1'b0;
        i_current_x_mm <= '0;
        i_current_y_mm <= '0;
        send_idle_pct <= 22;
        recv_idle_pct <= 63;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset defaults, goal at the origin: far corners first so the goal flag
        // is still clear, then the deadband, the zero vector and the -x axis.
        send_position(24'sd8388607, 24'sd8388607);
        send_position(-24'sd8388608, -24'sd8388608);
        send_position(24'sd8388607, -24'sd8388608);
        send_position(-24'sd8388608, 24'sd8388607);
        send_position(24'sd1000, 24'sd0);
        send_position(-24'sd1000, 24'sd0);
        send_position(24'sd0, -24'sd1000);
        send_position(24'sd0, 24'sd40);
        send_position(24'sd0, 24'sd0);
        send_position(24'sd1, 24'sd0);
        send_position(24'sd0, -24'sd1);

        // Goal in one corner, full gain and limit, no deadbands, done never sets.
        drain_and_pause();
        apply_settings(24'sd8388607, -24'sd8388608, 0, 65535, 4095, 0, 0);
        send_position(-24'sd8388608, 24'sd8388607);
        send_position(24'sd8388607, -24'sd8388608);
        send_position(24'sd8388606, -24'sd8388608);
        send_position(24'sd8388607, -24'sd8388607);

        // Opposite corner, zero gain and limit, widest deadbands.
        drain_and_pause();
        apply_settings(-24'sd8388608, 24'sd8388607, 65535, 0, 0, 3142, 4095);
        send_position(24'sd8388607, -24'sd8388608);
        send_position(24'sd8388607, 24'sd8388607);

        // Values on the edges of both deadbands and on the speed limit.
        drain_and_pause();
        apply_settings(24'sd0, 24'sd0, 100, 65535, 150, 785, 4095);
        send_position(-24'sd500, -24'sd500);
        send_position(-24'sd100, 24'sd0);
        send_position(-24'sd101, 24'sd0);
        send_position(-24'sd5000, 24'sd3);

        // Random part: three idling patterns, several register settings in each.
        for (int phase = 0; phase < 3; phase++) begin
            if (phase == 1) begin
                send_idle_pct <= 63;
                recv_idle_pct <= 22;
            end else if (phase == 2) begin
                send_idle_pct <= 0;
                recv_idle_pct <= 0;
            end
            for (int set = 0; set < SETS_PER_PHASE; set++) begin
                drain_and_pause();
                if ($urandom_range(1)) begin
                    tx = 24'($urandom);
                    ty = 24'($urandom);
                end else begin
                    tx = 24'(near(5000));
                    ty = 24'(near(5000));
                end
                apply_settings(tx, ty,
                               pick(0, 65535, $urandom_range(200), 65535),
                               pick(0, 65535, 13107, 65535),
                               pick(0, 4095, 200, 4095),
                               pick(0, 3142, $urandom_range(400), 4095),
                               pick(0, 4095, $urandom_range(50), 4095));
                // Hold the result side off while requests keep coming in.
                if (phase == 2 && set == 0) hold_requests <= hold_requests + 1;
                repeat (ITEMS_PER_SET) begin
                    kind = $urandom_range(99);
                    if (kind < 25) begin
                        x = 24'($urandom);
                        y = 24'($urandom);
                    end else if (kind < 55) begin
                        x = 24'(aim_x + near(2000));
                        y = 24'(aim_y + near(2000));
                    end else if (kind < 75) begin
                        x = 24'(aim_x + near(150));
                        y = 24'(aim_y + near(150));
                    end else if (kind < 85) begin
                        // On an axis through the goal, both directions.
                        if ($urandom_range(1)) begin
                            x = 24'(aim_x + near(3000));
                            y = aim_y;
                        end else begin
                            x = aim_x;
                            y = 24'(aim_y + near(3000));
                        end
                    end else if (kind < 90) begin
                        x = aim_x;
                        y = aim_y;
                    end else begin
                        x = 24'(aim_x + near(60000));
                        y = 24'(aim_y + near(60000));
                    end
                    send_position(x, y);
                end
            end
        end

        drain_and_pause();
        failures = mismatches + pending;
        $display("summary: %0d positions under %0d register settings, %0d commands compared",
                 positions_sent, settings_loaded, results);
        $display("summary: three idling patterns and one long result hold-off, %0d mismatches",
                 failures);
        if (failures == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
